// ===== rtl/core/akf_pkg.sv =====
// Shared constants, command types and saturation helpers for the angle Kalman filter.
package akf_pkg;

    localparam int NUM_AXES = 2;
    localparam int AXIS_W   = 1;

    localparam logic [23:0] DEFAULT_DT = 24'd167772;
    localparam logic [30:0] GAIN_MAX   = 31'h7FFF_FFFF;

    localparam logic [31:0] QA_RESET = 32'd4294967;
    localparam logic [31:0] QB_RESET = 32'd12884902;
    localparam logic [31:0] RM_RESET = 32'd128849019;

    // register indexes
    localparam logic [1:0] CFG_QA = 2'd0;
    localparam logic [1:0] CFG_QB = 2'd1;
    localparam logic [1:0] CFG_RM = 2'd2;

    // multiply selections
    localparam logic [3:0] MS_DT_RATE  = 4'd0;
    localparam logic [3:0] MS_DT_C11   = 4'd1;
    localparam logic [3:0] MS_DT_INNER = 4'd2;
    localparam logic [3:0] MS_PNB_DT   = 4'd3;
    localparam logic [3:0] MS_K0_Y     = 4'd4;
    localparam logic [3:0] MS_K1_Y     = 4'd5;
    localparam logic [3:0] MS_K0_P00   = 4'd6;
    localparam logic [3:0] MS_K0_P01   = 4'd7;
    localparam logic [3:0] MS_K1_P00   = 4'd8;
    localparam logic [3:0] MS_K1_P01   = 4'd9;

    // datapath operations
    localparam logic [4:0] OP_NONE  = 5'd0;
    localparam logic [4:0] OP_RATE  = 5'd1;
    localparam logic [4:0] OP_MLOAD = 5'd2;
    localparam logic [4:0] OP_MLO   = 5'd3;
    localparam logic [4:0] OP_MHI   = 5'd4;
    localparam logic [4:0] OP_MRND  = 5'd5;
    localparam logic [4:0] OP_MWB   = 5'd6;
    localparam logic [4:0] OP_I1    = 5'd7;
    localparam logic [4:0] OP_I2    = 5'd8;
    localparam logic [4:0] OP_I3    = 5'd9;
    localparam logic [4:0] OP_CX    = 5'd10;
    localparam logic [4:0] OP_S     = 5'd11;
    localparam logic [4:0] OP_DINIT = 5'd12;
    localparam logic [4:0] OP_DSTEP = 5'd13;
    localparam logic [4:0] OP_DFIN  = 5'd14;
    localparam logic [4:0] OP_P     = 5'd15;
    localparam logic [4:0] OP_STORE = 5'd16;

    localparam logic [4:0] DIV_STEPS_LAST = 5'd30;

    typedef struct packed {
        logic       accept;
        logic [4:0] op;
        logic [3:0] msel;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic axis_ok;
    } stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sh7FFF_FFFF;
        lo = ~hi;
        if (v > hi)
            sat32 = 32'sh7FFF_FFFF;
        else if (v < lo)
            sat32 = 32'sh8000_0000;
        else
            sat32 = v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sh7FFF_FFFF_FFFF;
        lo = ~hi;
        if (v > hi)
            sat48 = 48'sh7FFF_FFFF_FFFF;
        else if (v < lo)
            sat48 = 48'sh8000_0000_0000;
        else
            sat48 = v[47:0];
    endfunction

endpackage

// ===== rtl/core/angle_kalman_filter.sv =====
// Top level of the two-axis angle and gyro-bias Kalman filter.
//
//  port group   dir  payload (lowest bit first)
//  s_axis       in   axis, measured_angle, gyro_rate, interval
//  m_axis       out  out_axis, filtered_angle
//  cfg          in   noise registers: angle, bias, measurement
//
// Most of an update is spent on ten products on a shared 24x32 multiplier, each
// passing through load, low half, high half, round and write-back, and on the
// two gain divisions, run side by side at one quotient bit a cycle.
// Reset (rst_n low, asynchronous) clears the estimates and covariances of both
// axes and loads the default noise values; no clearing pass follows.
// A new beat is taken as soon as the previous one has reached the output
// register; a stalled output only holds the sequencer at its final step.
// Write the configuration only while the filter is idle.
module angle_kalman_filter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // axis, measured_angle, gyro_rate, interval
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_axis, filtered_angle
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_data
);

    akf_pkg::cmd_t  cmd;
    akf_pkg::stat_t stat;

    // sequencer: one step of the update per state
    akf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // arithmetic, per-axis state and the output register
    akf_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

endmodule

// ===== rtl/core/akf_ctrl.sv =====
// Sequencer for the angle Kalman filter: steps the datapath through one update.
module akf_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  akf_pkg::stat_t stat,
    output akf_pkg::cmd_t  cmd
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_RATE  = 5'd1;
    localparam logic [4:0] ST_MLOAD = 5'd2;
    localparam logic [4:0] ST_MLO   = 5'd3;
    localparam logic [4:0] ST_MHI   = 5'd4;
    localparam logic [4:0] ST_MRND  = 5'd5;
    localparam logic [4:0] ST_MWB   = 5'd6;
    localparam logic [4:0] ST_I1    = 5'd7;
    localparam logic [4:0] ST_I2    = 5'd8;
    localparam logic [4:0] ST_I3    = 5'd9;
    localparam logic [4:0] ST_CX    = 5'd10;
    localparam logic [4:0] ST_S     = 5'd11;
    localparam logic [4:0] ST_DINIT = 5'd12;
    localparam logic [4:0] ST_DSTEP = 5'd13;
    localparam logic [4:0] ST_DFIN  = 5'd14;
    localparam logic [4:0] ST_P     = 5'd15;
    localparam logic [4:0] ST_STORE = 5'd16;

    logic [4:0] state_reg, state_next;
    logic [3:0] msel_reg, msel_next;
    logic       ovalid_reg, ovalid_next;
    logic       go;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ovalid_reg;
    assign go        = !ovalid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        msel_next  = msel_reg;
        cmd.accept = 1'b0;
        cmd.op     = akf_pkg::OP_NONE;
        cmd.msel   = msel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && stat.axis_ok)
                    state_next = ST_RATE;
            end
            ST_RATE:
            begin
                cmd.op     = akf_pkg::OP_RATE;
                msel_next  = akf_pkg::MS_DT_RATE;
                state_next = ST_MLOAD;
            end
            ST_MLOAD:
            begin
                cmd.op     = akf_pkg::OP_MLOAD;
                state_next = ST_MLO;
            end
            ST_MLO:
            begin
                cmd.op     = akf_pkg::OP_MLO;
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                cmd.op     = akf_pkg::OP_MHI;
                state_next = ST_MRND;
            end
            ST_MRND:
            begin
                cmd.op     = akf_pkg::OP_MRND;
                state_next = ST_MWB;
            end
            ST_MWB:
            begin
                cmd.op = akf_pkg::OP_MWB;
                unique case (msel_reg)
                    akf_pkg::MS_DT_RATE:
                    begin
                        msel_next  = akf_pkg::MS_DT_C11;
                        state_next = ST_MLOAD;
                    end
                    akf_pkg::MS_DT_C11:   state_next = ST_I1;
                    akf_pkg::MS_DT_INNER: state_next = ST_CX;
                    akf_pkg::MS_PNB_DT:   state_next = ST_S;
                    akf_pkg::MS_K0_Y:
                    begin
                        msel_next  = akf_pkg::MS_K1_Y;
                        state_next = ST_MLOAD;
                    end
                    akf_pkg::MS_K1_Y:     state_next = ST_P;
                    akf_pkg::MS_K0_P00:
                    begin
                        msel_next  = akf_pkg::MS_K0_P01;
                        state_next = ST_MLOAD;
                    end
                    akf_pkg::MS_K0_P01:
                    begin
                        msel_next  = akf_pkg::MS_K1_P00;
                        state_next = ST_MLOAD;
                    end
                    akf_pkg::MS_K1_P00:
                    begin
                        msel_next  = akf_pkg::MS_K1_P01;
                        state_next = ST_MLOAD;
                    end
                    default:              state_next = ST_STORE;
                endcase
            end
            ST_I1:
            begin
                cmd.op     = akf_pkg::OP_I1;
                state_next = ST_I2;
            end
            ST_I2:
            begin
                cmd.op     = akf_pkg::OP_I2;
                state_next = ST_I3;
            end
            ST_I3:
            begin
                cmd.op     = akf_pkg::OP_I3;
                msel_next  = akf_pkg::MS_DT_INNER;
                state_next = ST_MLOAD;
            end
            ST_CX:
            begin
                cmd.op     = akf_pkg::OP_CX;
                msel_next  = akf_pkg::MS_PNB_DT;
                state_next = ST_MLOAD;
            end
            ST_S:
            begin
                cmd.op     = akf_pkg::OP_S;
                state_next = ST_DINIT;
            end
            ST_DINIT:
            begin
                cmd.op     = akf_pkg::OP_DINIT;
                state_next = ST_DSTEP;
            end
            ST_DSTEP:
            begin
                cmd.op = akf_pkg::OP_DSTEP;
                if (stat.div_last)
                    state_next = ST_DFIN;
            end
            ST_DFIN:
            begin
                cmd.op     = akf_pkg::OP_DFIN;
                msel_next  = akf_pkg::MS_K0_Y;
                state_next = ST_MLOAD;
            end
            ST_P:
            begin
                cmd.op     = akf_pkg::OP_P;
                msel_next  = akf_pkg::MS_K0_P00;
                state_next = ST_MLOAD;
            end
            ST_STORE:
            begin
                if (go)
                begin
                    cmd.op     = akf_pkg::OP_STORE;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.op == akf_pkg::OP_STORE)
            ovalid_next = 1'b1;
        else if (out_ready)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            msel_reg   <= akf_pkg::MS_DT_RATE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            msel_reg   <= msel_next;
            ovalid_reg <= ovalid_next;
        end
    end

    a_store_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == akf_pkg::OP_STORE) |=> ovalid_reg)
        else $error("result not presented after store");

    a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DSTEP && !stat.div_last) |=> (state_reg == ST_DSTEP))
        else $error("division left early");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && stat.axis_ok) |=> (state_reg == ST_RATE))
        else $error("accepted beat did not start an update");

    a_store_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STORE && ovalid_reg && !out_ready) |=> (state_reg == ST_STORE))
        else $error("result overwritten before it was taken");

endmodule

// ===== rtl/core/akf_dp.sv =====
// Datapath of the angle Kalman filter: state, shared multiplier, gain dividers.
module akf_dp
(
    input  logic           clk,
    input  logic           rst_n,
    input  akf_pkg::cmd_t  cmd,
    output akf_pkg::stat_t stat,
    input  logic [95:0]    in_data,
    output logic [39:0]    out_data,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_addr,
    input  logic [31:0]    cfg_data
);

    logic [31:0] qa_reg, qb_reg, rm_reg;

    logic signed [31:0] ang_arr  [akf_pkg::NUM_AXES];
    logic signed [31:0] bias_arr [akf_pkg::NUM_AXES];
    logic signed [47:0] c00_arr  [akf_pkg::NUM_AXES];
    logic signed [47:0] c01_arr  [akf_pkg::NUM_AXES];
    logic signed [47:0] c10_arr  [akf_pkg::NUM_AXES];
    logic signed [47:0] c11_arr  [akf_pkg::NUM_AXES];

    logic                axis_reg;
    logic signed [31:0]  meas_reg, gyro_reg, rate_reg;
    logic [23:0]         dt_reg;
    logic signed [31:0]  ang_reg, bias_reg, k0_reg, k1_reg;
    logic signed [47:0]  c00_reg, c01_reg, c10_reg, c11_reg;
    logic signed [47:0]  t1_reg, inner_reg, s_reg, p00_reg, p01_reg;
    logic signed [32:0]  y_reg;

    logic [47:0]         ma_reg;
    logic [31:0]         mb_reg;
    logic                mneg_reg;
    logic [79:0]         acc_reg;
    logic signed [48:0]  m_reg;

    logic [47:0]         us_reg;
    logic [48:0]         r0_reg, r1_reg;
    logic [30:0]         q0_reg, q1_reg;
    logic                neg0_reg, neg1_reg, big0_reg, big1_reg, zero_reg;
    logic [4:0]          dcnt_reg;

    logic                oaxis_reg;
    logic signed [31:0]  oangle_reg;

    logic                in_axis;
    logic [23:0]         in_dt;
    logic signed [48:0]  a_sel;
    logic signed [32:0]  b_sel;
    logic signed [48:0]  a_abs;
    logic signed [32:0]  b_abs;
    logic [80:0]         rsum, rshift, cap;
    logic                is32;
    logic [47:0]         mag;
    logic signed [48:0]  m_val;
    logic signed [49:0]  m50;
    logic [47:0]         us_val, un0_val, un1_val;
    logic [48:0]         t0_val, t1_val;
    logic                b0_bit, b1_bit;
    logic signed [31:0]  k0_val, k1_val;

    assign in_axis  = in_data[0];
    assign in_dt    = (in_data[88:65] == 24'd0) ? akf_pkg::DEFAULT_DT : in_data[88:65];
    assign out_data = {7'd0, oangle_reg, oaxis_reg};

    assign stat.axis_ok  = ({31'd0, in_axis} < 32'(akf_pkg::NUM_AXES));
    assign stat.div_last = (dcnt_reg == akf_pkg::DIV_STEPS_LAST);

    // multiplier operand selection
    always_comb
    begin
        unique case (cmd.msel)
            akf_pkg::MS_DT_RATE:
            begin
                a_sel = {25'd0, dt_reg};
                b_sel = {rate_reg[31], rate_reg};
            end
            akf_pkg::MS_DT_C11:
            begin
                a_sel = {c11_reg[47], c11_reg};
                b_sel = {9'd0, dt_reg};
            end
            akf_pkg::MS_DT_INNER:
            begin
                a_sel = {inner_reg[47], inner_reg};
                b_sel = {9'd0, dt_reg};
            end
            akf_pkg::MS_PNB_DT:
            begin
                a_sel = {25'd0, dt_reg};
                b_sel = {1'b0, qb_reg};
            end
            akf_pkg::MS_K0_Y:
            begin
                a_sel = {{16{y_reg[32]}}, y_reg};
                b_sel = {k0_reg[31], k0_reg};
            end
            akf_pkg::MS_K1_Y:
            begin
                a_sel = {{16{y_reg[32]}}, y_reg};
                b_sel = {k1_reg[31], k1_reg};
            end
            akf_pkg::MS_K0_P00:
            begin
                a_sel = {p00_reg[47], p00_reg};
                b_sel = {k0_reg[31], k0_reg};
            end
            akf_pkg::MS_K0_P01:
            begin
                a_sel = {p01_reg[47], p01_reg};
                b_sel = {k0_reg[31], k0_reg};
            end
            akf_pkg::MS_K1_P00:
            begin
                a_sel = {p00_reg[47], p00_reg};
                b_sel = {k1_reg[31], k1_reg};
            end
            default:
            begin
                a_sel = {p01_reg[47], p01_reg};
                b_sel = {k1_reg[31], k1_reg};
            end
        endcase
        a_abs = a_sel[48] ? -a_sel : a_sel;
        b_abs = b_sel[32] ? -b_sel : b_sel;
    end

    // round to nearest (ties away), shift and clamp the product magnitude
    always_comb
    begin
        is32 = (cmd.msel == akf_pkg::MS_DT_RATE) || (cmd.msel == akf_pkg::MS_K0_Y) ||
               (cmd.msel == akf_pkg::MS_K1_Y);
        if (cmd.msel == akf_pkg::MS_PNB_DT)
        begin
            rsum   = {1'b0, acc_reg} + (81'd1 << 15);
            rshift = rsum >> 16;
        end
        else if (cmd.msel == akf_pkg::MS_DT_RATE || cmd.msel == akf_pkg::MS_DT_C11 ||
                 cmd.msel == akf_pkg::MS_DT_INNER)
        begin
            rsum   = {1'b0, acc_reg} + (81'd1 << 23);
            rshift = rsum >> 24;
        end
        else
        begin
            rsum   = {1'b0, acc_reg} + (81'd1 << 29);
            rshift = rsum >> 30;
        end
        if (is32)
            cap = mneg_reg ? (81'd1 << 31) : ((81'd1 << 31) - 81'd1);
        else
            cap = mneg_reg ? (81'd1 << 47) : ((81'd1 << 47) - 81'd1);
        mag   = (rshift > cap) ? cap[47:0] : rshift[47:0];
        m_val = mneg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    assign m50 = {m_reg[48], m_reg};

    // divider: one restoring step per cycle on both numerators
    always_comb
    begin
        us_val  = s_reg[47] ? 48'(-s_reg) : s_reg;
        un0_val = c00_reg[47] ? 48'(-c00_reg) : c00_reg;
        un1_val = c10_reg[47] ? 48'(-c10_reg) : c10_reg;
        b0_bit  = (r0_reg >= {1'b0, us_reg});
        b1_bit  = (r1_reg >= {1'b0, us_reg});
        t0_val  = b0_bit ? (r0_reg - {1'b0, us_reg}) : r0_reg;
        t1_val  = b1_bit ? (r1_reg - {1'b0, us_reg}) : r1_reg;
        if (zero_reg)
            k0_val = 32'sd0;
        else if (big0_reg)
            k0_val = neg0_reg ? -$signed({1'b0, akf_pkg::GAIN_MAX})
                              : $signed({1'b0, akf_pkg::GAIN_MAX});
        else
            k0_val = neg0_reg ? -$signed({1'b0, q0_reg}) : $signed({1'b0, q0_reg});
        if (zero_reg)
            k1_val = 32'sd0;
        else if (big1_reg)
            k1_val = neg1_reg ? -$signed({1'b0, akf_pkg::GAIN_MAX})
                              : $signed({1'b0, akf_pkg::GAIN_MAX});
        else
            k1_val = neg1_reg ? -$signed({1'b0, q1_reg}) : $signed({1'b0, q1_reg});
    end

    // configuration and per-axis state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qa_reg <= akf_pkg::QA_RESET;
            qb_reg <= akf_pkg::QB_RESET;
            rm_reg <= akf_pkg::RM_RESET;
            for (int i = 0; i < akf_pkg::NUM_AXES; i++)
            begin
                ang_arr[i]  <= '0;
                bias_arr[i] <= '0;
                c00_arr[i]  <= '0;
                c01_arr[i]  <= '0;
                c10_arr[i]  <= '0;
                c11_arr[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    akf_pkg::CFG_QA: qa_reg <= cfg_data;
                    akf_pkg::CFG_QB: qb_reg <= cfg_data;
                    akf_pkg::CFG_RM: rm_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == akf_pkg::OP_STORE)
            begin
                ang_arr[axis_reg]  <= ang_reg;
                bias_arr[axis_reg] <= bias_reg;
                c00_arr[axis_reg]  <= c00_reg;
                c01_arr[axis_reg]  <= c01_reg;
                c10_arr[axis_reg]  <= c10_reg;
                c11_arr[axis_reg]  <= c11_reg;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            axis_reg <= in_axis;
            meas_reg <= in_data[32:1];
            gyro_reg <= in_data[64:33];
            dt_reg   <= in_dt;
            ang_reg  <= ang_arr[in_axis];
            bias_reg <= bias_arr[in_axis];
            c00_reg  <= c00_arr[in_axis];
            c01_reg  <= c01_arr[in_axis];
            c10_reg  <= c10_arr[in_axis];
            c11_reg  <= c11_arr[in_axis];
        end
        unique case (cmd.op)
            akf_pkg::OP_RATE:
                rate_reg <= akf_pkg::sat32({{18{gyro_reg[31]}}, gyro_reg} -
                                           {{18{bias_reg[31]}}, bias_reg});
            akf_pkg::OP_MLOAD:
            begin
                ma_reg   <= a_abs[47:0];
                mb_reg   <= b_abs[31:0];
                mneg_reg <= a_sel[48] ^ b_sel[32];
            end
            akf_pkg::OP_MLO:
                acc_reg <= {24'd0, 56'(ma_reg[23:0]) * 56'(mb_reg)};
            akf_pkg::OP_MHI:
                acc_reg <= acc_reg + {56'(ma_reg[47:24]) * 56'(mb_reg), 24'd0};
            akf_pkg::OP_MRND:
                m_reg <= m_val;
            akf_pkg::OP_MWB:
            begin
                unique case (cmd.msel)
                    akf_pkg::MS_DT_RATE, akf_pkg::MS_K0_Y:
                        ang_reg <= akf_pkg::sat32({{18{ang_reg[31]}}, ang_reg} + m50);
                    akf_pkg::MS_K1_Y:
                        bias_reg <= akf_pkg::sat32({{18{bias_reg[31]}}, bias_reg} + m50);
                    akf_pkg::MS_DT_C11:
                        t1_reg <= m_reg[47:0];
                    akf_pkg::MS_DT_INNER:
                        c00_reg <= akf_pkg::sat48({{2{c00_reg[47]}}, c00_reg} + m50);
                    akf_pkg::MS_PNB_DT:
                        c11_reg <= akf_pkg::sat48({{2{c11_reg[47]}}, c11_reg} + m50);
                    akf_pkg::MS_K0_P00:
                        c00_reg <= akf_pkg::sat48({{2{c00_reg[47]}}, c00_reg} - m50);
                    akf_pkg::MS_K0_P01:
                        c01_reg <= akf_pkg::sat48({{2{c01_reg[47]}}, c01_reg} - m50);
                    akf_pkg::MS_K1_P00:
                        c10_reg <= akf_pkg::sat48({{2{c10_reg[47]}}, c10_reg} - m50);
                    default:
                        c11_reg <= akf_pkg::sat48({{2{c11_reg[47]}}, c11_reg} - m50);
                endcase
            end
            akf_pkg::OP_I1:
                inner_reg <= akf_pkg::sat48({{2{t1_reg[47]}}, t1_reg} -
                                            {{2{c01_reg[47]}}, c01_reg});
            akf_pkg::OP_I2:
                inner_reg <= akf_pkg::sat48({{2{inner_reg[47]}}, inner_reg} -
                                            {{2{c10_reg[47]}}, c10_reg});
            akf_pkg::OP_I3:
                inner_reg <= akf_pkg::sat48({{2{inner_reg[47]}}, inner_reg} +
                                            {10'd0, qa_reg, 8'd0});
            akf_pkg::OP_CX:
            begin
                c01_reg <= akf_pkg::sat48({{2{c01_reg[47]}}, c01_reg} -
                                          {{2{t1_reg[47]}}, t1_reg});
                c10_reg <= akf_pkg::sat48({{2{c10_reg[47]}}, c10_reg} -
                                          {{2{t1_reg[47]}}, t1_reg});
            end
            akf_pkg::OP_S:
            begin
                s_reg <= akf_pkg::sat48({{2{c00_reg[47]}}, c00_reg} + {10'd0, rm_reg, 8'd0});
                y_reg <= {meas_reg[31], meas_reg} - {ang_reg[31], ang_reg};
            end
            akf_pkg::OP_DINIT:
            begin
                us_reg   <= us_val;
                r0_reg   <= {1'b0, un0_val};
                r1_reg   <= {1'b0, un1_val};
                big0_reg <= ({1'b0, un0_val} >= {us_val, 1'b0});
                big1_reg <= ({1'b0, un1_val} >= {us_val, 1'b0});
                neg0_reg <= c00_reg[47] ^ s_reg[47];
                neg1_reg <= c10_reg[47] ^ s_reg[47];
                zero_reg <= (s_reg == 48'sd0);
                q0_reg   <= '0;
                q1_reg   <= '0;
                dcnt_reg <= '0;
            end
            akf_pkg::OP_DSTEP:
            begin
                q0_reg   <= {q0_reg[29:0], b0_bit};
                q1_reg   <= {q1_reg[29:0], b1_bit};
                r0_reg   <= {t0_val[47:0], 1'b0};
                r1_reg   <= {t1_val[47:0], 1'b0};
                dcnt_reg <= dcnt_reg + 5'd1;
            end
            akf_pkg::OP_DFIN:
            begin
                k0_reg <= k0_val;
                k1_reg <= k1_val;
            end
            akf_pkg::OP_P:
            begin
                p00_reg <= c00_reg;
                p01_reg <= c01_reg;
            end
            akf_pkg::OP_STORE:
            begin
                oaxis_reg  <= axis_reg;
                oangle_reg <= ang_reg;
            end
            default: ;
        endcase
    end

endmodule
